// ===== sv/rfb_pkg.sv =====
// Shared types, constants and the CRC step for the radio frame builder.
`default_nettype none

package rfb_pkg;

   localparam logic [7:0]  PREAMBLE_BYTE = 8'hAA;
   localparam logic [7:0]  SYNC_BYTE     = 8'h2D;
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;

   // CSR indexes
   localparam logic [7:0] REG_GROUP_ID     = 8'd0;
   localparam logic [7:0] REG_HEADER_VALUE = 8'd1;
   localparam logic [7:0] REG_LENGTH_VALUE = 8'd2;
   localparam logic [7:0] REG_SENSOR_ID    = 8'd3;

   localparam logic [7:0] RST_GROUP_ID     = 8'hD4;
   localparam logic [7:0] RST_HEADER_VALUE = 8'h00;
   localparam logic [7:0] RST_LENGTH_VALUE = 8'h04;
   localparam logic [7:0] RST_SENSOR_ID    = 8'h41;

   // One classified request waiting for the back end.
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       last_byte;
      logic       open_head;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } slot_type;

   // Reflected CRC-16, one byte folded in.
   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== sv/rfb_if.sv =====
// Handshake interfaces for request, response and CSR channels.
`default_nettype none

interface rfb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       last_byte;
   modport source (output valid, output payload_byte, output last_byte, input ready);
   modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface rfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       end_of_run;
   logic       end_of_frame;
   modport source (output valid, output tx_byte, output end_of_run, output end_of_frame,
                   input ready);
   modport sink   (input valid, input tx_byte, input end_of_run, input end_of_frame,
                   output ready);
endinterface

interface rfb_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/rfb_front.sv =====
// Front end: accepts requests and marks the ones that open a frame.
`default_nettype none

module rfb_front (
   input  wire logic         clock,
   input  wire logic         reset,
   rfb_req_if.sink           req_chan,
   input  wire logic         queue_full,
   output rfb_pkg::slot_type push
);
   import rfb_pkg::*;

   logic frame_open_ff;
   logic frame_open_in;
   logic accept;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;

   always_comb begin
      push.valid              = accept;
      push.entry.payload_byte = req_chan.payload_byte;
      push.entry.last_byte    = req_chan.last_byte;
      push.entry.open_head    = !frame_open_ff;
      frame_open_in           = frame_open_ff;
      if (accept) begin
         frame_open_in = !req_chan.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
      end else begin
         frame_open_ff <= frame_open_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/rfb_queue.sv =====
// Short queue between front and back end.
`default_nettype none

module rfb_queue #(
   parameter int Depth = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rfb_pkg::slot_type push,
   input  wire logic              pop,
   output logic                   full,
   output rfb_pkg::slot_type      head
);
   import rfb_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   entry_type           mem_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == CntW'(Depth));
   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

`default_nettype wire

// ===== sv/rfb_back.sv =====
// Back end: CSRs, byte sequencer, running CRC and the response register.
`default_nettype none

module rfb_back (
   input  wire logic              clock,
   input  wire logic              reset,
   rfb_csr_if.sink                csr_chan,
   input  wire rfb_pkg::slot_type head,
   output logic                   pop,
   rfb_rsp_if.source              rsp_chan
);
   import rfb_pkg::*;

   typedef enum logic [3:0] {
      ST_START = 4'b0001,
      ST_HEAD  = 4'b0010,
      ST_DATA  = 4'b0100,
      ST_TAIL  = 4'b1000
   } seq_state_type;

   logic [7:0] group_id_ff, header_value_ff, length_value_ff, sensor_id_ff;

   seq_state_type state_ff, state_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic [15:0]   crc_ff, crc_in;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_eor_ff, out_eor_in;
   logic       out_eof_ff, out_eof_in;

   logic       advance;
   logic [7:0] head_byte;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         group_id_ff     <= RST_GROUP_ID;
         header_value_ff <= RST_HEADER_VALUE;
         length_value_ff <= RST_LENGTH_VALUE;
         sensor_id_ff    <= RST_SENSOR_ID;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_GROUP_ID:     group_id_ff     <= csr_chan.data;
            REG_HEADER_VALUE: header_value_ff <= csr_chan.data;
            REG_LENGTH_VALUE: length_value_ff <= csr_chan.data;
            REG_SENSOR_ID:    sensor_id_ff    <= csr_chan.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cnt_ff)
         3'd3:    head_byte = SYNC_BYTE;
         3'd4:    head_byte = group_id_ff;
         3'd5:    head_byte = header_value_ff;
         3'd6:    head_byte = length_value_ff;
         3'd7:    head_byte = sensor_id_ff;
         default: head_byte = PREAMBLE_BYTE;
      endcase
   end

   assign advance = head.valid && (!out_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      crc_in      = crc_ff;
      pop         = 1'b0;
      out_byte_in = out_byte_ff;
      out_eor_in  = out_eor_ff;
      out_eof_in  = out_eof_ff;
      if (advance) begin
         out_eor_in = 1'b0;
         out_eof_in = 1'b0;
         unique case (state_ff)
            ST_START, ST_DATA: begin
               if (state_ff == ST_START && head.entry.open_head) begin
                  out_byte_in = PREAMBLE_BYTE;
                  cnt_in      = 3'd1;
                  state_in    = ST_HEAD;
               end else begin
                  out_byte_in = head.entry.payload_byte;
                  crc_in      = crc_fold(crc_ff, head.entry.payload_byte);
                  cnt_in      = 3'd0;
                  if (head.entry.last_byte) begin
                     state_in = ST_TAIL;
                  end else begin
                     out_eor_in = 1'b1;
                     pop        = 1'b1;
                     state_in   = ST_START;
                  end
               end
            end
            ST_HEAD: begin
               out_byte_in = head_byte;
               cnt_in      = cnt_ff + 1'b1;
               // group byte restarts the CRC for this frame
               if (cnt_ff == 3'd4) begin
                  crc_in = crc_fold(CRC_INIT, head_byte);
               end else if (cnt_ff > 3'd4) begin
                  crc_in = crc_fold(crc_ff, head_byte);
               end
               if (cnt_ff == 3'd7) begin
                  state_in = ST_DATA;
               end
            end
            ST_TAIL: begin
               cnt_in = cnt_ff + 1'b1;
               unique case (cnt_ff[1:0])
                  2'd0:    out_byte_in = crc_ff[7:0];
                  2'd1:    out_byte_in = crc_ff[15:8];
                  2'd2:    out_byte_in = PREAMBLE_BYTE;
                  default: begin
                     out_byte_in = PREAMBLE_BYTE;
                     out_eor_in  = 1'b1;
                     out_eof_in  = 1'b1;
                     pop         = 1'b1;
                     cnt_in      = 3'd0;
                     state_in    = ST_START;
                  end
               endcase
            end
            default: state_in = ST_START;
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_START;
         cnt_ff       <= '0;
         crc_ff       <= CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_eor_ff  <= out_eor_in;
      out_eof_ff  <= out_eof_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.tx_byte      = out_byte_ff;
   assign rsp_chan.end_of_run   = out_eor_ff;
   assign rsp_chan.end_of_frame = out_eof_ff;

endmodule

`default_nettype wire

// ===== sv/radio_frame_builder_crc16_top.sv =====
// Radio frame builder top level.
//
// Each payload-byte request yields 1 to 13 response bytes, one per clock while
// the response side is ready: 8 head bytes (preamble, sync, group, header,
// length, sensor id) before the first byte of a frame, the byte itself, and
// CRC low, CRC high and two trailer bytes after a byte marked last. A byte in
// the middle of a frame yields just that byte, so the sustained rate is one
// request per clock; frame edges add the head and trailer bytes. The rate is
// set by the back-end sequencer, which drives one byte per clock into the
// response register. A queue of QueueDepth requests sits between the front end
// and the sequencer, so requests keep coming in while head or trailer bytes go
// out. The reflected CRC-16 (0xA001, start 0xFFFF) restarts at each frame. CSRs
// are read as each head byte is sent, so a write can reach a head in progress.
`default_nettype none

module radio_frame_builder_crc16_top #(
   parameter int QueueDepth = 2
) (
   input  wire logic clock,
   input  wire logic reset,
   rfb_req_if.sink   req_chan,
   rfb_rsp_if.source rsp_chan,
   rfb_csr_if.sink   csr_chan
);
   import rfb_pkg::*;

   slot_type push;
   slot_type head;
   logic     queue_full;
   logic     pop;

   rfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push)
   );

   rfb_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   rfb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
